FILE: rtl/core/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared widths, constants, sector codes and stage-enable struct for the
// HSV to RGB converter. No dependencies.
package hsv2rgb_pkg;

  // Field widths of the input request
  localparam int HUE_W = 9;
  localparam int PCT_W = 7;

  // Output level width; full scale is 2^OUT_BITS - 1
  localparam int OUT_BITS = 8;

  localparam int HUE_MAX = 359;
  localparam int PCT_MAX = 100;

  // Hue-derived terms
  localparam int TMOD_W = 7;   // hue mod 120, 0..119
  localparam int WT_W   = 6;   // 60 - |t - 60|, 0..60
  localparam int SV_W   = 14;  // s*v, 0..10000
  localparam int COMP_W = 20;  // component in 1/600000 of full scale

  localparam int TOP_SCALE    = 6000;
  localparam int CHROMA_SCALE = 60;

  // Rounding divide by the component denominator
  localparam longint unsigned SCALE_DEN = 64'd600000;
  localparam longint unsigned HALF_DEN  = SCALE_DEN / 64'd2;
  localparam longint unsigned FULL_SCALE = (64'd1 << OUT_BITS) - 64'd1;
  localparam longint unsigned X_MAX = SCALE_DEN * FULL_SCALE + HALF_DEN;
  localparam int X_W = $clog2(X_MAX + 64'd1);
  // Reciprocal, truncated: the estimate is low by at most one
  localparam longint unsigned REC_M = (64'd1 << X_W) / SCALE_DEN;
  localparam int M_W = $clog2(REC_M + 64'd1);
  localparam int P_W = X_W + M_W;

  // Six 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_0   = 3'd0,  // R top, G mid, B low
    SEC_60  = 3'd1,  // R mid, G top, B low
    SEC_120 = 3'd2,  // R low, G top, B mid
    SEC_180 = 3'd3,  // R low, G mid, B top
    SEC_240 = 3'd4,  // R mid, G low, B top
    SEC_300 = 3'd5   // R top, G low, B mid
  } sector_t;

  // Load enables of the three scaling stages
  typedef struct packed {
    logic x_ld;
    logic q_ld;
    logic lvl_ld;
  } scale_en_t;

endpackage
`default_nettype wire

FILE: rtl/core/hsv2rgb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for HSV requests and RGB results.
// Depends on hsv2rgb_pkg for field widths.
interface hsv2rgb_in_if import hsv2rgb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HUE_W-1:0]    hue_degrees;
  logic [PCT_W-1:0]    saturation_pct;
  logic [PCT_W-1:0]    value_pct;

  modport source (output valid, hue_degrees, saturation_pct, value_pct, input ready);
  modport sink   (input valid, hue_degrees, saturation_pct, value_pct, output ready);
endinterface

interface hsv2rgb_out_if import hsv2rgb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] red_level;
  logic [OUT_BITS-1:0] green_level;
  logic [OUT_BITS-1:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hsv2rgb_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// Three-stage rounding scale of one component to an output level:
// floor((comp*FS + D/2) / D) by reciprocal multiply and one correction.
// Depends on hsv2rgb_pkg.
module hsv2rgb_scale import hsv2rgb_pkg::*; (
  input  wire logic                clk,
  input  wire scale_en_t           en,
  input  wire logic [COMP_W-1:0]   comp,
  output logic      [OUT_BITS-1:0] level
);

  logic [X_W-1:0]      x_r, x_nxt;
  logic [X_W-1:0]      x2_r;
  logic [OUT_BITS-1:0] q_r, q_nxt;
  logic [OUT_BITS-1:0] lvl_r, lvl_nxt;
  logic [P_W-1:0]      prod;
  logic [X_W-1:0]      rem;

  // comp*FS is comp*2^n - comp; add half the denominator to round
  assign x_nxt = (X_W'(comp) << OUT_BITS) - X_W'(comp) + X_W'(HALF_DEN);

  // Estimate is the true quotient or one below
  assign prod  = P_W'(x_r) * P_W'(REC_M);
  assign q_nxt = OUT_BITS'(prod >> X_W);

  assign rem     = x2_r - X_W'(q_r) * X_W'(SCALE_DEN);
  assign lvl_nxt = (rem >= X_W'(SCALE_DEN)) ? q_r + OUT_BITS'(1) : q_r;

  always_ff @(posedge clk) begin
    if (en.x_ld) begin
      x_r <= x_nxt;
    end
    if (en.q_ld) begin
      q_r  <= q_nxt;
      x2_r <= x_r;
    end
    if (en.lvl_ld) begin
      lvl_r <= lvl_nxt;
    end
  end

  assign level = lvl_r;

endmodule
`default_nettype wire

FILE: rtl/core/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// HSV to RGB converter, six-stage pipeline with valid bits per stage.
// Throughput: one request per cycle; a stall holds each occupied stage that has no
// empty stage after it, and bubbles close up since each stage loads when it is empty.
// Reset (rst_n, synchronous, active low) clears all stage valid bits.
// Depends on hsv2rgb_pkg, hsv2rgb_in_if/hsv2rgb_out_if and hsv2rgb_scale.
module hsv_to_rgb_converter_top import hsv2rgb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  hsv2rgb_in_if.sink     in_ch,
  hsv2rgb_out_if.source  out_ch
);

  // ---------------------------------------------------------------------
  // Stage valid bits and ready chain. Stage k loads whenever it is empty
  // or its content moves on; stages 4..6 live in the scale lanes.
  // ---------------------------------------------------------------------
  logic [5:0] vld_r, vld_nxt;
  logic [5:0] rdy;
  scale_en_t  sc_en;

  always_comb begin
    rdy[5] = !vld_r[5] || out_ch.ready;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_ch.valid;
    end
    for (int k = 1; k < 6; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = rdy[0];
  assign sc_en.x_ld   = rdy[3];
  assign sc_en.q_ld   = rdy[4];
  assign sc_en.lvl_ld = rdy[5];

  // ---------------------------------------------------------------------
  // Stage 1: clamp the request, find the sector and the secondary weight
  // 60 - |(hue mod 120) - 60|.
  // ---------------------------------------------------------------------
  logic [HUE_W-1:0]  hue_c;
  logic [PCT_W-1:0]  sat_c, val_c;
  logic [TMOD_W-1:0] tmod, tdev;
  sector_t           sec1_nxt, sec1_r;
  logic [WT_W-1:0]   wt1_nxt, wt1_r;
  logic [PCT_W-1:0]  sat1_r, val1_r;

  always_comb begin
    hue_c = (in_ch.hue_degrees > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : in_ch.hue_degrees;
    sat_c = (in_ch.saturation_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                     : in_ch.saturation_pct;
    val_c = (in_ch.value_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_ch.value_pct;

    if (hue_c >= HUE_W'(240)) begin
      tmod = TMOD_W'(hue_c - HUE_W'(240));
    end else if (hue_c >= HUE_W'(120)) begin
      tmod = TMOD_W'(hue_c - HUE_W'(120));
    end else begin
      tmod = TMOD_W'(hue_c);
    end
    tdev    = (tmod >= TMOD_W'(60)) ? tmod - TMOD_W'(60) : TMOD_W'(60) - tmod;
    wt1_nxt = WT_W'(TMOD_W'(60) - tdev);

    if (hue_c < HUE_W'(60)) begin
      sec1_nxt = SEC_0;
    end else if (hue_c < HUE_W'(120)) begin
      sec1_nxt = SEC_60;
    end else if (hue_c < HUE_W'(180)) begin
      sec1_nxt = SEC_120;
    end else if (hue_c < HUE_W'(240)) begin
      sec1_nxt = SEC_180;
    end else if (hue_c < HUE_W'(300)) begin
      sec1_nxt = SEC_240;
    end else begin
      sec1_nxt = SEC_300;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sec1_r <= sec1_nxt;
      wt1_r  <= wt1_nxt;
      sat1_r <= sat_c;
      val1_r <= val_c;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: s*v and the top term v*6000.
  // ---------------------------------------------------------------------
  logic [SV_W-1:0]   sv2_nxt, sv2_r;
  logic [COMP_W-1:0] top2_nxt, top2_r;
  sector_t           sec2_r;
  logic [WT_W-1:0]   wt2_r;

  assign sv2_nxt  = SV_W'(sat1_r) * SV_W'(val1_r);
  assign top2_nxt = COMP_W'(val1_r) * COMP_W'(TOP_SCALE);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sv2_r  <= sv2_nxt;
      top2_r <= top2_nxt;
      sec2_r <= sec1_r;
      wt2_r  <= wt1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: chroma, then low = top - chroma and mid = sv*weight + low.
  // ---------------------------------------------------------------------
  logic [COMP_W-1:0] chroma, mpart;
  logic [COMP_W-1:0] low3_nxt, mid3_nxt;
  logic [COMP_W-1:0] top3_r, mid3_r, low3_r;
  sector_t           sec3_r;

  assign chroma   = COMP_W'(sv2_r) * COMP_W'(CHROMA_SCALE);
  assign mpart    = COMP_W'(sv2_r) * COMP_W'(wt2_r);
  assign low3_nxt = top2_r - chroma;
  assign mid3_nxt = mpart + low3_nxt;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      top3_r <= top2_r;
      mid3_r <= mid3_nxt;
      low3_r <= low3_nxt;
      sec3_r <= sec2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Route top/mid/low to R, G, B by sector, then scale each in its lane.
  // ---------------------------------------------------------------------
  logic [COMP_W-1:0] red_comp, grn_comp, blu_comp;

  always_comb begin
    case (sec3_r)
      SEC_0: begin
        red_comp = top3_r; grn_comp = mid3_r; blu_comp = low3_r;
      end
      SEC_60: begin
        red_comp = mid3_r; grn_comp = top3_r; blu_comp = low3_r;
      end
      SEC_120: begin
        red_comp = low3_r; grn_comp = top3_r; blu_comp = mid3_r;
      end
      SEC_180: begin
        red_comp = low3_r; grn_comp = mid3_r; blu_comp = top3_r;
      end
      SEC_240: begin
        red_comp = mid3_r; grn_comp = low3_r; blu_comp = top3_r;
      end
      default: begin
        red_comp = top3_r; grn_comp = low3_r; blu_comp = mid3_r;
      end
    endcase
  end

  hsv2rgb_scale u_scale_red (
    .clk   (clk),
    .en    (sc_en),
    .comp  (red_comp),
    .level (out_ch.red_level)
  );

  hsv2rgb_scale u_scale_grn (
    .clk   (clk),
    .en    (sc_en),
    .comp  (grn_comp),
    .level (out_ch.green_level)
  );

  hsv2rgb_scale u_scale_blu (
    .clk   (clk),
    .en    (sc_en),
    .comp  (blu_comp),
    .level (out_ch.blue_level)
  );

  // Result request is presented straight from the last stage
  assign out_ch.valid = vld_r[5];

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hsv_to_rgb_converter_top: it predicts every RGB result
// of a request and checks the result stream in order. Depends on hsv2rgb_pkg and
// the hsv2rgb_in_if / hsv2rgb_out_if channel interfaces.

import hsv2rgb_pkg::*;

// Saturation limits and level denominator used by the predictor
localparam int unsigned HUE_CAP = 359;
localparam int unsigned PCT_CAP = 100;
localparam longint unsigned LEVEL_DEN = 600000;

typedef logic [HUE_W-1:0]    hue_t;
typedef logic [PCT_W-1:0]    pct_t;
typedef logic [OUT_BITS-1:0] level_t;

typedef struct packed {
  level_t red;
  level_t green;
  level_t blue;
} rgb_levels_t;

typedef struct packed {
  hue_t        hue;
  pct_t        sat;
  pct_t        val;
  rgb_levels_t rgb;
} rgb_expect_t;

class rgb_checker;
  rgb_expect_t pending_rgb[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned reported;

  function new();
    errors   = 0;
    checked  = 0;
    reported = 0;
  endfunction

  // Round comp/600000 of full scale to the nearest level, ties up
  static function level_t scale_level(int unsigned comp);
    longint unsigned fs;
    longint unsigned lvl;
    fs  = (64'd1 << OUT_BITS) - 64'd1;
    lvl = (64'(comp) * fs + LEVEL_DEN / 2) / LEVEL_DEN;
    return level_t'(lvl);
  endfunction

  static function rgb_levels_t predict_rgb(hue_t hue, pct_t sat, pct_t val);
    int unsigned h, s, v, t, tdev, top, chroma, low, mid, r, g, b;
    sector_t sec;
    rgb_levels_t res;
    h = (hue > HUE_CAP) ? HUE_CAP : hue;
    s = (sat > PCT_CAP) ? PCT_CAP : sat;
    v = (val > PCT_CAP) ? PCT_CAP : val;
    t      = h % 120;
    tdev   = (t >= 60) ? (t - 60) : (60 - t);
    top    = v * 6000;
    chroma = s * v * 60;
    low    = top - chroma;
    mid    = s * v * (60 - tdev) + low;
    sec    = sector_t'(3'(h / 60));
    case (sec)
      SEC_0: begin
        r = top; g = mid; b = low;
      end
      SEC_60: begin
        r = mid; g = top; b = low;
      end
      SEC_120: begin
        r = low; g = top; b = mid;
      end
      SEC_180: begin
        r = low; g = mid; b = top;
      end
      SEC_240: begin
        r = mid; g = low; b = top;
      end
      default: begin
        r = top; g = low; b = mid;
      end
    endcase
    res.red   = scale_level(r);
    res.green = scale_level(g);
    res.blue  = scale_level(b);
    return res;
  endfunction

  function void flag(string msg);
    errors++;
    if (reported < 10) begin
      reported++;
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  function void note_request(hue_t hue, pct_t sat, pct_t val);
    rgb_expect_t e;
    e.hue = hue;
    e.sat = sat;
    e.val = val;
    e.rgb = predict_rgb(hue, sat, val);
    pending_rgb.push_back(e);
  endfunction

  function void check_result(level_t r, level_t g, level_t b);
    rgb_expect_t e;
    if (pending_rgb.size() == 0) begin
      flag($sformatf("result rgb=(%0d,%0d,%0d) with no request pending", r, g, b));
      return;
    end
    e = pending_rgb.pop_front();
    checked++;
    if (r !== e.rgb.red || g !== e.rgb.green || b !== e.rgb.blue)
      flag($sformatf("hsv=(%0d,%0d,%0d) expected rgb=(%0d,%0d,%0d) got (%0d,%0d,%0d)",
                     e.hue, e.sat, e.val, e.rgb.red, e.rgb.green, e.rgb.blue, r, g, b));
  endfunction

  function int pending();
    return pending_rgb.size();
  endfunction

  // Fail every request that never produced a result
  function void close_out();
    rgb_expect_t e;
    while (pending_rgb.size() != 0) begin
      e = pending_rgb.pop_front();
      flag($sformatf("no result for hsv=(%0d,%0d,%0d)", e.hue, e.sat, e.val));
    end
  endfunction
endclass

module tb;
  logic clk;
  logic rst_n;

  hsv2rgb_in_if  in_ch ();
  hsv2rgb_out_if out_ch ();

  hsv_to_rgb_converter_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rgb_checker board = new();

  // calm: suppress idling on both sides; rx_hold_len: receiver hold-off request
  bit          calm = 1'b0;
  int unsigned rx_hold_len = 0;
  int unsigned holds_done = 0;
  int unsigned sent = 0;
  int unsigned sent_oor = 0;
  int unsigned drains = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Offer one request, idling first at random, and hold it until accepted.
  // Called at a rising edge; returns at the edge that took the request.
  task automatic push_request(input hue_t h, input pct_t s, input pct_t v);
    if (!calm && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.hue_degrees    <= h;
    in_ch.saturation_pct <= s;
    in_ch.value_pct      <= v;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(h, s, v);
    sent++;
    if (h > HUE_CAP || s > PCT_CAP || v > PCT_CAP)
      sent_oor++;
  endtask

  // Drop valid and wait until every outstanding request has its result
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    drains++;
  endtask

  // Random request: mostly in range, some on sector edges, some over full width
  task automatic push_random();
    int unsigned kind;
    hue_t h;
    pct_t s, v;
    kind = $urandom_range(99);
    if (kind < 75) begin
      h = hue_t'($urandom_range(0, HUE_CAP));
      s = pct_t'($urandom_range(0, PCT_CAP));
      v = pct_t'($urandom_range(0, PCT_CAP));
    end else if (kind < 85) begin
      h = hue_t'(60 * $urandom_range(0, 5) + ($urandom_range(1) ? 0 : 59));
      s = $urandom_range(1) ? pct_t'($urandom_range(1) ? PCT_CAP : 0)
                            : pct_t'($urandom_range(0, PCT_CAP));
      v = $urandom_range(1) ? pct_t'($urandom_range(1) ? PCT_CAP : 0)
                            : pct_t'($urandom_range(0, PCT_CAP));
    end else begin
      h = hue_t'($urandom_range(0, (1 << HUE_W) - 1));
      s = pct_t'($urandom_range(0, (1 << PCT_W) - 1));
      v = pct_t'($urandom_range(0, (1 << PCT_W) - 1));
    end
    push_request(h, s, v);
  endtask

  // Receiver: stall at random, or hold off for a requested stretch
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
        holds_done++;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  // Result monitor: values read here are the ones present at the edge
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_result(out_ch.red_level, out_ch.green_level, out_ch.blue_level);
    end
  end

  // Main sequence
  initial begin
    int unsigned guard;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.hue_degrees    <= '0;
    in_ch.saturation_pct <= '0;
    in_ch.value_pct      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every sector edge at full color, grey and black,
    // saturation of each field, and alternating bit patterns
    push_request(9'd0,   7'd100, 7'd100);
    push_request(9'd59,  7'd100, 7'd100);
    push_request(9'd60,  7'd100, 7'd100);
    push_request(9'd119, 7'd100, 7'd100);
    push_request(9'd120, 7'd100, 7'd100);
    push_request(9'd179, 7'd100, 7'd100);
    push_request(9'd180, 7'd100, 7'd100);
    push_request(9'd239, 7'd100, 7'd100);
    push_request(9'd240, 7'd100, 7'd100);
    push_request(9'd299, 7'd100, 7'd100);
    push_request(9'd300, 7'd100, 7'd100);
    push_request(9'd359, 7'd100, 7'd100);
    push_request(9'd30,  7'd0,   7'd100);
    push_request(9'd90,  7'd100, 7'd0);
    push_request(9'd210, 7'd50,  7'd50);
    push_request(9'd360, 7'd100, 7'd100);
    push_request(9'd511, 7'd127, 7'd127);
    push_request(9'd150, 7'd101, 7'd80);
    push_request(9'd270, 7'd60,  7'd101);
    push_request(9'd45,  7'd127, 7'd0);
    push_request(9'd330, 7'd0,   7'd127);
    push_request(9'd1,   7'd1,   7'd1);
    push_request(9'd85,  7'd85,  7'd42);
    push_request(9'd426, 7'd42,  7'd85);
    drain_pipe();

    // Random traffic with pressure points and a quiet stretch
    for (int i = 0; i < 700; i++) begin
      if (i == 120)
        rx_hold_len = 64;     // fill the pipe while the sender keeps offering
      if (i == 250 || i == 600)
        drain_pipe();         // let the block run fully dry mid-stream
      calm = (i >= 350 && i < 470);
      push_random();
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // Wait out the tail, bounded, before closing out the checker
    guard = 0;
    while (board.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
    board.close_out();

    $display("summary: %0d requests (%0d with saturated fields), %0d results checked",
             sent, sent_oor, board.checked);
    $display("summary: %0d receiver hold-offs, %0d full drains, %0d failures",
             holds_done, drains, board.errors);
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_if.sv
rtl/core/hsv2rgb_scale.sv
rtl/core/hsv_to_rgb_converter_top.sv
dv/tb.sv
